/* src/dhfc_pkg.sv */
package dhfc_pkg;

    localparam int WordW  = 64;
    localparam int QDepth = 2;

    typedef enum logic
    {
        FUNC_TO_HEX   = 1'b0,
        FUNC_FROM_HEX = 1'b1
    } func_t;

    typedef enum logic [2:0]
    {
        CLS_NORMAL = 3'b001,
        CLS_ZERO   = 3'b010,
        CLS_SPEC   = 3'b100
    } cls_t;

    // Classified work item passed from front to back.
    typedef struct packed
    {
        func_t       func;
        cls_t        cls;
        logic [63:0] operand;
        logic [5:0]  lead;
    } item_t;

    // Double bits of 1e-77; magnitudes strictly below TinyBits are tiny.
    localparam logic [62:0] TinyBits = 63'h2FF2_86D8_0EC1_90DC;

    localparam logic [63:0] SatMag = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

/* src/dhfc_front.sv */
module dhfc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [63:0]          operand_bits,
    output logic                 q_valid,
    input  logic                 q_ready,
    output dhfc_pkg::item_t      q_item
);
    import dhfc_pkg::*;

    item_t      item;
    logic [5:0] lead;
    logic       found;

    // leading one of the hex fraction
    always_comb
    begin
        lead  = 6'd0;
        found = 1'b0;
        for (int i = 55; i >= 0; i--)
        begin
            if (!found && operand_bits[i])
            begin
                lead  = 6'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        item.func    = func_t'(func);
        item.operand = operand_bits;
        item.lead    = lead;
        if (func == FUNC_FROM_HEX)
            item.cls = (operand_bits[55:0] == '0) ? CLS_ZERO : CLS_NORMAL;
        else if (operand_bits[62:52] == 11'h7FF)
            item.cls = CLS_SPEC;
        else if (operand_bits[62:0] < TinyBits)
            item.cls = CLS_ZERO;
        else
            item.cls = CLS_NORMAL;
    end

    item_t q_reg [QDepth];
    logic  wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic  push, pop;

    assign in_ready = (cnt_reg != 2'(QDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* src/dhfc_back.sv */
module dhfc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  dhfc_pkg::item_t      q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          result_bits,
    output logic                 overflow,
    output logic                 flushed_to_zero
);
    import dhfc_pkg::*;

    logic [63:0] res;
    logic        ovf, flz;
    logic        sgn;
    logic [10:0] bexp;
    logic [11:0] t;
    logic [9:0]  hexp_b;
    logic [55:0] fr;
    logic [55:0] fr_n;
    logic [2:0]  r;
    logic [52:0] sig;
    logic [2:0]  rem;
    logic [2:0]  half;
    logic [53:0] sig_r;
    logic [5:0]  p;
    logic [10:0] uexp;

    always_comb
    begin
        sgn    = q_item.operand[63];
        bexp   = q_item.operand[62:52];
        t      = 12'(bexp) + 12'd125;
        hexp_b = t[11:2];
        fr     = 56'({1'b1, q_item.operand[51:0]}) << t[1:0];
        fr_n   = q_item.operand[55:0] << (6'd55 - q_item.lead);
        p      = q_item.lead;
        r      = (p > 6'd52) ? 3'(p - 6'd52) : 3'd0;
        sig    = fr_n[55:3];
        rem    = 3'd0;
        half   = 3'd0;
        unique case (r)
            3'd1:    begin rem = {2'b0, q_item.operand[0]};   half = 3'd1; end
            3'd2:    begin rem = {1'b0, q_item.operand[1:0]}; half = 3'd2; end
            3'd3:    begin rem = q_item.operand[2:0];         half = 3'd4; end
            default: ;
        endcase
        sig_r = {1'b0, sig};
        if (r != 3'd0 && (rem > half || (rem == half && sig[0])))
            sig_r = sig_r + 54'd1;
        if (sig_r[53])
            p = p + 6'd1;
        uexp = 11'(p) + 11'({q_item.operand[62:56], 2'b00}) - 11'd256 - 11'd56 + 11'd1023;
        res = '0;
        ovf = 1'b0;
        flz = 1'b0;
        if (q_item.func == FUNC_FROM_HEX)
        begin
            if (q_item.cls == CLS_ZERO)
                res = {sgn, 63'd0};
            else
                res = {sgn, uexp, sig_r[53] ? sig_r[52:1] : sig_r[51:0]};
        end
        else
        begin
            unique case (q_item.cls)
                CLS_SPEC:
                begin
                    res = (q_item.operand[51:0] != '0) ? SatMag : {sgn, SatMag[62:0]};
                    ovf = 1'b1;
                end
                CLS_ZERO:
                begin
                    res = {sgn && (q_item.operand[62:0] != '0), 7'h40, 56'd0};
                    flz = (q_item.operand[62:0] != '0);
                end
                default:
                begin
                    // hexp+64 = t/4 - 222; overflow when >= 128
                    if (hexp_b >= 10'd350)
                    begin
                        res = {sgn, SatMag[62:0]};
                        ovf = 1'b1;
                    end
                    else
                        res = {sgn, 7'(hexp_b - 10'd222), fr};
                end
            endcase
        end
    end

    logic        v_reg;
    logic [63:0] res_reg;
    logic        ovf_reg, flz_reg;

    assign q_ready         = !v_reg || out_ready;
    assign out_valid       = v_reg;
    assign result_bits     = res_reg;
    assign overflow        = ovf_reg;
    assign flushed_to_zero = flz_reg;

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            res_reg <= res;
            ovf_reg <= ovf;
            flz_reg <= flz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (q_ready)
            v_reg <= q_valid;
    end

endmodule

/* src/double_hex_float_converter_unit.sv */
// Double / hex-float converter.
// Input channel: in_valid/in_ready with func and operand_bits. func 0 turns
// IEEE double bits into excess-64 base-16 real, func 1 the reverse.
// Output channel: out_valid/out_ready with result_bits, overflow and
// flushed_to_zero; one result per input transfer, in order.
// Path: the input transfer writes the queue, and the back register loads
// the converted item from the queue when it is free (out_valid low or
// out_ready high); out_valid rises with that load.
// Throughput: one transfer per cycle while out_ready is high.
// The two-entry queue between front and back lets the input side keep
// accepting while the output register waits on out_ready; when the
// receiver stalls, in_ready drops once the queue and output are full.
// Reset empties the queue and clears out_valid; no item is lost or
// replayed across a stall.
module double_hex_float_converter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_bits,
    output logic        overflow,
    output logic        flushed_to_zero
);
    import dhfc_pkg::*;

    item_t q_item;
    logic  q_valid, q_ready;

    dhfc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .operand_bits (operand_bits),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    dhfc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_bits     (result_bits),
        .overflow        (overflow),
        .flushed_to_zero (flushed_to_zero)
    );

endmodule

/* src/dhfc_checker.sv */
module dhfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_bits,
    input logic        overflow,
    input logic        flushed_to_zero
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && flushed_to_zero))
        else $error("overflow and flush together");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bits))
        else $error("result changed under stall");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready |=> ##1 out_valid)
        else $error("result missing after transfer");

    a_flz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flushed_to_zero |-> result_bits[62:0] == 63'h4000_0000_0000_0000)
        else $error("flushed result not zero");

endmodule

bind double_hex_float_converter_unit dhfc_checker u_chk
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_bits     (result_bits),
    .overflow        (overflow),
    .flushed_to_zero (flushed_to_zero)
);
